[design/assert_macros.svh]
// assertion helpers shared by the scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define FCPS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("fcps assertion failed");

// consequence checked in the cycle after the antecedent
`define FCPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcps assertion failed");

`endif

[design/fcps_pkg.sv]
package fcps_pkg;

	localparam int COORD_BITS = 12;
	localparam int RADIUS_BITS = 8;
	localparam int DELTA_BITS = 10;
	localparam int POS_BITS = 14;
	localparam int ROW_BITS = 15;
	localparam int DIM_BITS = 13;
	localparam int SQ_BITS = 16;
	localparam int COLOR_BITS = 32;
	localparam int OFS_BITS = 27;

	localparam logic [DIM_BITS-1:0] WIDTH_RESET = 13'd1024;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd768;

	// op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// register indexes
	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// queue depths
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW = 2;
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW = 3;

	// one scanned offset, handed from front to back
	typedef struct packed {
		logic idle;
		logic done;
		logic signed [DELTA_BITS-1:0] dx;
		logic signed [DELTA_BITS-1:0] dy;
		logic signed [POS_BITS-1:0] x;
		logic signed [POS_BITS-1:0] y;
		logic [SQ_BITS-1:0] r2;
		logic [COLOR_BITS-1:0] color;
	} job_t;

	// one finished result word
	typedef struct packed {
		logic pixel_write;
		logic off_frame;
		logic [OFS_BITS-1:0] byte_offset;
		logic [COLOR_BITS-1:0] pixel_color;
		logic done_res;
	} res_t;

endpackage

[design/fcps_front.sv]
`include "assert_macros.svh"

module fcps_front (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic op,
	input  logic [fcps_pkg::COORD_BITS-1:0] center_x,
	input  logic [fcps_pkg::COORD_BITS-1:0] center_y,
	input  logic [fcps_pkg::RADIUS_BITS-1:0] radius,
	input  logic [fcps_pkg::COLOR_BITS-1:0] fill_color,
	output logic job_push,
	output fcps_pkg::job_t job
);

	logic busy_q;
	logic [fcps_pkg::DELTA_BITS-1:0] dx_q;
	logic [fcps_pkg::DELTA_BITS-1:0] dy_q;
	logic [fcps_pkg::COORD_BITS-1:0] cx_q;
	logic [fcps_pkg::COORD_BITS-1:0] cy_q;
	logic [fcps_pkg::RADIUS_BITS-1:0] r_q;
	logic [fcps_pkg::SQ_BITS-1:0] r2_q;
	logic [fcps_pkg::COLOR_BITS-1:0] color_q;

	logic [fcps_pkg::DELTA_BITS-1:0] r_ext;
	logic [fcps_pkg::DELTA_BITS-1:0] dx_inc;
	logic [fcps_pkg::DELTA_BITS-1:0] dy_inc;
	logic wrap_x;
	logic wrap_y;

	assign r_ext = {2'b00, r_q};
	assign dx_inc = dx_q + 10'd1;
	assign dy_inc = dy_q + 10'd1;
	assign wrap_x = (dx_inc == r_ext);
	assign wrap_y = (dy_inc == r_ext);

	assign job_push = accept && (op == fcps_pkg::OP_TICK);

	always_comb begin
		job = '0;
		job.idle = !busy_q;
		// a tick with no scan running reports done
		job.done = !busy_q;
		if (busy_q) begin
			job.done = wrap_x && wrap_y;
			job.dx = $signed(dx_q);
			job.dy = $signed(dy_q);
			job.x = $signed({2'b00, cx_q}) + $signed({{4{dx_q[9]}}, dx_q});
			job.y = $signed({2'b00, cy_q}) + $signed({{4{dy_q[9]}}, dy_q});
			job.r2 = r2_q;
			job.color = color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dx_q <= '0;
			dy_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			r_q <= '0;
			r2_q <= '0;
			color_q <= '0;
		end else if (accept) begin
			if (op == fcps_pkg::OP_START) begin
				cx_q <= center_x;
				cy_q <= center_y;
				r_q <= radius;
				r2_q <= {8'd0, radius} * {8'd0, radius};
				color_q <= fill_color;
				dx_q <= 10'd0 - {2'b00, radius};
				dy_q <= 10'd0 - {2'b00, radius};
				busy_q <= (radius != '0);
			end else if (busy_q) begin
				if (wrap_x) begin
					dx_q <= 10'd0 - r_ext;
					if (wrap_y) begin
						dy_q <= 10'd0 - r_ext;
						busy_q <= 1'b0;
					end else begin
						dy_q <= dy_inc;
					end
				end else begin
					dx_q <= dx_inc;
				end
			end
		end
	end

	// scan position stays inside the bounding square
	`FCPS_ASSERT(a_dx_range, clk, arst_n, !busy_q || ($signed(dx_q) < $signed(r_ext) && $signed(dx_q) >= -$signed(r_ext)))
	// a zero radius start leaves the scanner idle
	`FCPS_ASSERT_NEXT(a_zero_radius, clk, arst_n, accept && op == fcps_pkg::OP_START && radius == '0, !busy_q)

endmodule

[design/fcps_jobq.sv]
`include "assert_macros.svh"

module fcps_jobq (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fcps_pkg::job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output fcps_pkg::job_t head
);

	fcps_pkg::job_t mem_q [fcps_pkg::JOBQ_DEPTH];
	logic [fcps_pkg::JOBQ_AW-1:0] wr_ptr_q;
	logic [fcps_pkg::JOBQ_AW-1:0] rd_ptr_q;
	logic [fcps_pkg::JOBQ_AW:0] cnt_q;

	assign full = (cnt_q == (fcps_pkg::JOBQ_AW+1)'(fcps_pkg::JOBQ_DEPTH));
	assign valid = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// fill level tracks the pointers
	`FCPS_ASSERT(a_ptr_level, clk, arst_n, (wr_ptr_q - rd_ptr_q) == cnt_q[fcps_pkg::JOBQ_AW-1:0])

endmodule

[design/fcps_back.sv]
`include "assert_macros.svh"

module fcps_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [fcps_pkg::DIM_BITS-1:0] frame_width,
	input  logic [fcps_pkg::DIM_BITS-1:0] frame_height,
	input  logic job_valid,
	input  fcps_pkg::job_t job,
	output logic job_pop,
	input  logic pop,
	output logic empty,
	output fcps_pkg::res_t res
);

	// stage valids
	logic v_s1, v_s2, v_s3;

	// stage 1: registered job
	fcps_pkg::job_t job_s1;

	// stage 2: squares and frame checks
	logic [fcps_pkg::SQ_BITS-1:0] dx2_s2, dy2_s2, r2_s2;
	logic [fcps_pkg::DIM_BITS-1:0] row_s2, x_s2;
	logic inf_s2, idle_s2, done_s2;
	logic [fcps_pkg::COLOR_BITS-1:0] color_s2;

	// stage 3: circle test and row product
	logic inside_s3, inf_s3, idle_s3, done_s3;
	logic [2*fcps_pkg::DIM_BITS-1:0] prod_s3;
	logic [fcps_pkg::DIM_BITS-1:0] x_s3;
	logic [fcps_pkg::COLOR_BITS-1:0] color_s3;

	// output queue
	fcps_pkg::res_t outq_q [fcps_pkg::OUTQ_DEPTH];
	logic [fcps_pkg::OUTQ_AW-1:0] owr_q, ord_q;
	logic [fcps_pkg::OUTQ_AW:0] ocnt_q;

	logic [1:0] inflight;
	logic [fcps_pkg::OUTQ_AW+1:0] credit_use;
	logic out_pop;
	logic signed [2*fcps_pkg::DELTA_BITS-1:0] dx_sq, dy_sq;
	logic signed [fcps_pkg::ROW_BITS-1:0] row_c;
	logic x_in, row_in;
	logic [2*fcps_pkg::DIM_BITS-2:0] lin;
	fcps_pkg::res_t res_c;

	assign inflight = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);
	assign credit_use = (fcps_pkg::OUTQ_AW+2)'(ocnt_q) + (fcps_pkg::OUTQ_AW+2)'(inflight);
	assign job_pop = job_valid && (credit_use < (fcps_pkg::OUTQ_AW+2)'(fcps_pkg::OUTQ_DEPTH));

	assign empty = (ocnt_q == '0);
	assign out_pop = pop && !empty;
	assign res = outq_q[ord_q];

	always_comb begin
		dx_sq = job_s1.dx * job_s1.dx;
		dy_sq = job_s1.dy * job_s1.dy;
		row_c = $signed({2'b00, frame_height}) - $signed({job_s1.y[13], job_s1.y});
		x_in = !job_s1.x[13] && (job_s1.x[12:0] < frame_width);
		row_in = !row_c[14] && (row_c[13:0] < {1'b0, frame_height});
	end

	always_comb begin
		lin = prod_s3[24:0] + {12'd0, x_s3};
		res_c = '0;
		res_c.done_res = done_s3;
		if (!idle_s3) begin
			res_c.pixel_write = inside_s3 && inf_s3;
			res_c.off_frame = !inf_s3;
			res_c.byte_offset = inf_s3 ? {lin, 2'b00} : '0;
			res_c.pixel_color = color_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_s1 <= job;
		end
		dx2_s2 <= dx_sq[15:0];
		dy2_s2 <= dy_sq[15:0];
		r2_s2 <= job_s1.r2;
		row_s2 <= row_c[12:0];
		x_s2 <= job_s1.x[12:0];
		inf_s2 <= x_in && row_in;
		idle_s2 <= job_s1.idle;
		done_s2 <= job_s1.done;
		color_s2 <= job_s1.color;
		inside_s3 <= ({1'b0, dx2_s2} + {1'b0, dy2_s2}) <= {1'b0, r2_s2};
		prod_s3 <= row_s2 * frame_width;
		x_s3 <= x_s2;
		inf_s3 <= inf_s2;
		idle_s3 <= idle_s2;
		done_s3 <= done_s2;
		color_s3 <= color_s2;
		if (v_s3) begin
			outq_q[owr_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			owr_q <= '0;
			ord_q <= '0;
			ocnt_q <= '0;
		end else begin
			v_s1 <= job_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				owr_q <= owr_q + 1'b1;
			end
			if (out_pop) begin
				ord_q <= ord_q + 1'b1;
			end
			unique case ({v_s3, out_pop})
				2'b10: ocnt_q <= ocnt_q + 1'b1;
				2'b01: ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	// every word in flight has a reserved output slot
	`FCPS_ASSERT(a_credit, clk, arst_n, credit_use <= (fcps_pkg::OUTQ_AW+2)'(fcps_pkg::OUTQ_DEPTH))
	// an issued job passes through the s1, s2 and s3 stage registers before it reaches the output queue
	`FCPS_ASSERT(a_latency, clk, arst_n, v_s3 == $past(job_pop, 3))

endmodule

[design/filled_circle_pixel_scanner.sv]
// filled circle pixel scanner
//
// input word (push/full): op selects start or tick. a start loads center_x,
// center_y, radius and fill_color and yields no result. each tick yields one
// result word for the next offset of the bounding square (rows outer, columns
// inner, -r to r-1); a tick with no scan running yields a word with only
// done_res set. done_res also marks the last offset of a scan.
// result word (empty/pop): pixel_write, off_frame, byte_offset, pixel_color,
// done_res; the oldest word sits on the ports while empty is low.
// frame_width and frame_height are written through wr_en/wr_index/wr_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. path: a tick passes through the job queue, three
// back-end stages and the output queue. throughput: one word per clock while
// the output queue has room.
// reset: frame registers go to 1024 x 768, no scan running, both queues empty.
// when pop stays low the 8-word output queue fills, the back end stops drawing
// from the 4-word job queue, and full rises once that fills too.
module filled_circle_pixel_scanner (
	input  logic clk,
	input  logic arst_n,
	// input channel
	input  logic push,
	output logic full,
	input  logic op,
	input  logic [11:0] center_x,
	input  logic [11:0] center_y,
	input  logic [7:0] radius,
	input  logic [31:0] fill_color,
	// result channel
	output logic empty,
	input  logic pop,
	output logic pixel_write,
	output logic off_frame,
	output logic [26:0] byte_offset,
	output logic [31:0] pixel_color,
	output logic done_res,
	// config write port
	input  logic wr_en,
	input  logic wr_index,
	input  logic [12:0] wr_data
);

	// frame size registers
	logic [fcps_pkg::DIM_BITS-1:0] width_q;
	logic [fcps_pkg::DIM_BITS-1:0] height_q;

	logic accept;
	logic job_push;
	fcps_pkg::job_t front_job;
	logic jobq_full;
	logic jobq_valid;
	logic jobq_pop;
	fcps_pkg::job_t jobq_head;
	fcps_pkg::res_t res;

	// a word is taken whenever the job queue has room
	assign full = jobq_full;
	assign accept = push && !jobq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= fcps_pkg::WIDTH_RESET;
			height_q <= fcps_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				fcps_pkg::REG_FRAME_WIDTH: width_q <= wr_data;
				fcps_pkg::REG_FRAME_HEIGHT: height_q <= wr_data;
				default: width_q <= width_q;
			endcase
		end
	end

	// front: holds the scan position, turns ticks into jobs
	fcps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.op(op),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.fill_color(fill_color),
		.job_push(job_push),
		.job(front_job)
	);

	// short queue decoupling front and back
	fcps_jobq u_jobq (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_job(front_job),
		.full(jobq_full),
		.pop(jobq_pop),
		.valid(jobq_valid),
		.head(jobq_head)
	);

	// back: circle test, frame check, offset math, output queue
	fcps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.frame_width(width_q),
		.frame_height(height_q),
		.job_valid(jobq_valid),
		.job(jobq_head),
		.job_pop(jobq_pop),
		.pop(pop),
		.empty(empty),
		.res(res)
	);

	assign pixel_write = res.pixel_write;
	assign off_frame = res.off_frame;
	assign byte_offset = res.byte_offset;
	assign pixel_color = res.pixel_color;
	assign done_res = res.done_res;

endmodule
